// File: sv/smsd_pkg.sv
// shared constants and types for the sliding median spike detector
// no dependencies

package smsd_pkg;

   localparam int unsigned WINDOW_MAX_DEF  = 256;
   localparam int unsigned SAMPLE_BITS_DEF = 16;

   localparam int unsigned LEN_W      = 9;
   localparam int unsigned NOTICE_W   = 24;
   localparam logic [NOTICE_W-1:0] NOTICE_MAX = {NOTICE_W{1'b1}};

   localparam int unsigned CSR_ADDR_W     = 3;
   localparam int unsigned CSR_DATA_W     = 32;
   localparam int unsigned REG_WINDOW_LEN = 0;
   localparam logic [LEN_W-1:0] WINDOW_LEN_RESET = LEN_W'(1);

   typedef struct packed {
      logic clear;
      logic update;
      logic remove;
   } smsd_cell_ctl_type;

endpackage

// File: sv/smsd_ram.sv
// generic single write port ram with registered read
// no dependencies

module smsd_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 256
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/smsd_cell.sv
// one cell of the sorted window chain: removes the oldest value and inserts the new one
// depends on smsd_pkg

module smsd_cell
   import smsd_pkg::*;
#(
   parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  smsd_cell_ctl_type        ctl,
   input  logic [SAMPLE_BITS-1:0]   sample,
   input  logic [SAMPLE_BITS-1:0]   old,
   input  logic [SAMPLE_BITS:0]     left_w,
   input  logic [SAMPLE_BITS:0]     right_key,
   output logic [SAMPLE_BITS:0]     w_out,
   output logic [SAMPLE_BITS:0]     key
);

   localparam int unsigned KEY_W = SAMPLE_BITS + 1;
   localparam logic [KEY_W-1:0] KEY_EMPTY = {1'b1, {SAMPLE_BITS{1'b0}}};

   logic [KEY_W-1:0] key_ff;
   logic [KEY_W-1:0] key_in;
   logic [KEY_W-1:0] sample_key;
   logic [KEY_W-1:0] old_key;

   assign sample_key = KEY_W'(sample);
   assign old_key    = KEY_W'(old);

   // list after removal, as seen from this slot
   assign w_out = (ctl.remove && (key_ff >= old_key)) ? right_key : key_ff;

   always_comb begin
      priority if (ctl.clear) begin
         key_in = KEY_EMPTY;
      end else if (ctl.update) begin
         priority if (w_out <= sample_key) begin
            key_in = w_out;
         end else if (left_w <= sample_key) begin
            key_in = sample_key;
         end else begin
            key_in = left_w;
         end
      end else begin
         key_in = key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= KEY_EMPTY;
      end else begin
         key_ff <= key_in;
      end
   end

   assign key = key_ff;

endmodule

// File: sv/sliding_median_spike_detector.sv
// Sliding window median spike detector. Each sample beat goes through, in order: accept
// (compare against twice the median of the window before it, ring write), chain update
// (all sorted cells at once remove the oldest value, once the window is full, and insert
// the new one), and median tap capture into the median tap register that follows the
// sorted cell chain; the next sample is accepted only after tap capture. A result beat
// waits in an output register, and the next accept is held off until that beat is taken.
// Writing window_len empties the window.
// depends on smsd_pkg, smsd_cell, smsd_ram

module sliding_median_spike_detector
   import smsd_pkg::*;
#(
   parameter int unsigned WINDOW_MAX  = WINDOW_MAX_DEF,
   parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [SAMPLE_BITS-1:0]  req_sample,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_notify,
   output logic                    rsp_window_full,
   output logic [NOTICE_W-1:0]     rsp_notice_count,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [CSR_DATA_W-1:0]   csr_pwdata,
   output logic [CSR_DATA_W-1:0]   csr_prdata,
   output logic                    csr_pready
);

   localparam int unsigned IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int unsigned CNT_W = $clog2(WINDOW_MAX + 1);
   localparam int unsigned EXT_W = (LEN_W > CNT_W) ? LEN_W : CNT_W;
   localparam int unsigned KEY_W = SAMPLE_BITS + 1;
   localparam logic [EXT_W-1:0] WMAX_EXT = EXT_W'(WINDOW_MAX);
   localparam logic [KEY_W-1:0] KEY_EMPTY = {1'b1, {SAMPLE_BITS{1'b0}}};

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_UPDATE = 3'b010,
      ST_SETTLE = 3'b100
   } state_type;

   state_type               state_ff, state_in;
   logic [LEN_W-1:0]        len_ff, len_in;
   logic [IDX_W-1:0]        head_ff, head_in;
   logic [CNT_W-1:0]        seen_ff, seen_in;
   logic [NOTICE_W-1:0]     notices_ff, notices_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_notify_ff, rsp_full_ff;
   logic [NOTICE_W-1:0]     rsp_count_ff;
   logic [SAMPLE_BITS-1:0]  sample_ff, old_ff;
   logic                    remove_ff;
   logic [SAMPLE_BITS-1:0]  med_lo_ff, med_lo_in, med_hi_ff, med_hi_in;

   logic [EXT_W-1:0]        len_ext;
   logic [CNT_W-1:0]        eff_len;
   logic [IDX_W-1:0]        hi_idx, lo_idx;
   logic [SAMPLE_BITS:0]    thr;
   logic                    full, flag;
   logic                    req_fire, cfg_write, cfg_hit;
   logic [SAMPLE_BITS-1:0]  ring_rdata;
   smsd_cell_ctl_type       cell_ctl;

   logic [KEY_W-1:0]        keys [WINDOW_MAX];
   logic [KEY_W-1:0]        ws   [WINDOW_MAX];

   // effective window length
   assign len_ext = EXT_W'(len_ff);
   always_comb begin
      priority if (len_ext == '0) begin
         eff_len = CNT_W'(1);
      end else if (len_ext > WMAX_EXT) begin
         eff_len = CNT_W'(WMAX_EXT);
      end else begin
         eff_len = CNT_W'(len_ext);
      end
   end

   assign hi_idx = IDX_W'(eff_len >> 1);
   assign lo_idx = eff_len[0] ? hi_idx : hi_idx - IDX_W'(1);

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign cfg_hit   = (csr_paddr[CSR_ADDR_W-1:2] == (CSR_ADDR_W-2)'(REG_WINDOW_LEN));
   assign cfg_write = csr_psel && csr_penable && csr_pwrite && csr_pready && cfg_hit;

   assign full = (seen_ff >= eff_len);
   assign thr  = KEY_W'(med_lo_ff) + KEY_W'(med_hi_ff);
   assign flag = full && (KEY_W'(req_sample) >= thr);

   // ring of samples in arrival order
   smsd_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (WINDOW_MAX)
   ) u_ring (
      .clock   (clock),
      .wr_en   (req_fire),
      .wr_addr (head_ff),
      .wr_data (req_sample),
      .rd_addr (head_ff),
      .rd_data (ring_rdata)
   );

   // sorted chain
   assign cell_ctl.clear  = cfg_write;
   assign cell_ctl.update = (state_ff == ST_UPDATE);
   assign cell_ctl.remove = remove_ff;

   for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
      logic [KEY_W-1:0] left_w;
      logic [KEY_W-1:0] right_key;
      if (k == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_mid
         assign left_w = ws[k-1];
      end
      if (k == WINDOW_MAX - 1) begin : g_last
         assign right_key = KEY_EMPTY;
      end else begin : g_inner
         assign right_key = keys[k+1];
      end
      smsd_cell #(
         .SAMPLE_BITS (SAMPLE_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (cell_ctl),
         .sample    (sample_ff),
         .old       (old_ff),
         .left_w    (left_w),
         .right_key (right_key),
         .w_out     (ws[k]),
         .key       (keys[k])
      );
   end

   // median taps
   always_comb begin
      med_lo_in = '0;
      med_hi_in = '0;
      for (int k = 0; k < WINDOW_MAX; k++) begin
         if (IDX_W'(k) == lo_idx) begin
            med_lo_in = keys[k][SAMPLE_BITS-1:0];
         end
         if (IDX_W'(k) == hi_idx) begin
            med_hi_in = keys[k][SAMPLE_BITS-1:0];
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      head_in      = head_ff;
      seen_in      = seen_ff;
      notices_in   = notices_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in = ST_SETTLE;
         end
         ST_SETTLE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (req_fire) begin
         rsp_valid_in = 1'b1;
         if (flag && (notices_ff != NOTICE_MAX)) begin
            notices_in = notices_ff + NOTICE_W'(1);
         end
         seen_in = full ? eff_len : seen_ff + CNT_W'(1);
         head_in = ((CNT_W'(head_ff) + CNT_W'(1)) == eff_len) ? '0 : head_ff + IDX_W'(1);
      end
      if (cfg_write) begin
         len_in  = csr_pwdata[LEN_W-1:0];
         seen_in = '0;
         head_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= WINDOW_LEN_RESET;
         head_ff      <= '0;
         seen_ff      <= '0;
         notices_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         remove_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         head_ff      <= head_in;
         seen_ff      <= seen_in;
         notices_ff   <= notices_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            remove_ff <= full;
         end
      end
   end

   always_ff @(posedge clock) begin
      med_lo_ff <= med_lo_in;
      med_hi_ff <= med_hi_in;
      if (req_fire) begin
         sample_ff     <= req_sample;
         old_ff        <= ring_rdata;
         rsp_notify_ff <= flag;
         rsp_full_ff   <= full;
         rsp_count_ff  <= notices_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_notify       = rsp_notify_ff;
   assign rsp_window_full  = rsp_full_ff;
   assign rsp_notice_count = rsp_count_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = cfg_hit ? CSR_DATA_W'(len_ff) : '0;

`ifndef SYNTHESIS
   a_seen_bounded: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= eff_len)
      else $error("window fill exceeds window length");

   a_head_bounded: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(head_ff) < eff_len)
      else $error("ring head outside window");

   a_accept_update: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_UPDATE))
      else $error("accepted beat did not start chain update");

   a_notices_grow: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (notices_ff >= $past(notices_ff)))
      else $error("notice counter went backward");
`endif

endmodule

// File: bench/tb_sliding_median_spike_detector.sv
// self-checking bench for sliding_median_spike_detector: predicts each result beat from its own
// copy of the window and compares every field; also writes and reads back window_len
// depends on smsd_pkg and the sliding_median_spike_detector rtl

module tb_sliding_median_spike_detector;
   import smsd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned WATCHDOG_LIMIT = 5000;
   localparam int unsigned LONG_HOLD      = 400;
   localparam int unsigned REG_UNUSED     = 1;
   localparam logic [CSR_ADDR_W-1:0] ADDR_WINDOW_LEN = CSR_ADDR_W'(4 * REG_WINDOW_LEN);
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNUSED     = CSR_ADDR_W'(4 * REG_UNUSED);

   typedef logic [SAMPLE_BITS_DEF-1:0] sample_type;

   typedef struct packed {
      logic                notify;
      logic                window_full;
      logic [NOTICE_W-1:0] notice_count;
   } spike_verdict_type;

   typedef enum {
      SHAPE_LOW_SPIKE,
      SHAPE_DUPES,
      SHAPE_UNIFORM,
      SHAPE_EDGES,
      SHAPE_MIXED
   } sample_shape_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   sample_type            req_sample = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_notify;
   logic                  rsp_window_full;
   logic [NOTICE_W-1:0]   rsp_notice_count;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   sliding_median_spike_detector dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_notify       (rsp_notify),
      .rsp_window_full  (rsp_window_full),
      .rsp_notice_count (rsp_notice_count),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   // predictor state
   sample_type          ring_mem [WINDOW_MAX_DEF];
   sample_type          sort_mem [WINDOW_MAX_DEF];
   int unsigned         ring_pos = 0;
   int unsigned         fill_cnt = 0;
   logic [NOTICE_W-1:0] notice_tally = '0;
   logic [LEN_W-1:0]    len_reg = WINDOW_LEN_RESET;

   sample_type        sample_q [$];
   spike_verdict_type verdict_q [$];

   logic        send_idle = 1'b0;
   logic        recv_idle = 1'b0;
   int unsigned send_gap = 0;
   int unsigned recv_gap = 0;
   int unsigned long_asks = 0;
   int unsigned long_seen = 0;
   int unsigned fail_count = 0;
   int unsigned quiet_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void queue_sample(sample_type s);
      sample_q.insert(sample_q.size(), s);
   endfunction

   function automatic void queue_verdict(spike_verdict_type v);
      verdict_q.insert(verdict_q.size(), v);
   endfunction

   function automatic void note_mismatch(string what, longint unsigned want,
                                         longint unsigned got);
      fail_count++;
      if (fail_count <= 10)
         $display("mismatch on %s: expected %0d, got %0d", what, want, got);
   endfunction

   function automatic int unsigned idle_draw(logic enable);
      return enable ? $urandom_range(0, 17) : 0;
   endfunction

   function automatic int unsigned active_len();
      if (len_reg == 0) return 1;
      if (len_reg > WINDOW_MAX_DEF) return WINDOW_MAX_DEF;
      return int'(len_reg);
   endfunction

   function automatic void sorted_add(int unsigned cnt, sample_type v);
      int unsigned k;
      k = cnt;
      while (k > 0 && sort_mem[k-1] > v) begin
         sort_mem[k] = sort_mem[k-1];
         k--;
      end
      sort_mem[k] = v;
   endfunction

   function automatic spike_verdict_type predict_spike(sample_type s);
      spike_verdict_type v;
      int unsigned       len;
      int unsigned       slot;
      int unsigned       k;
      logic [16:0]       twice_med;
      sample_type        oldest;
      v = '0;
      len = active_len();
      slot = ring_pos % len;
      if (fill_cnt >= len) begin
         v.window_full = 1'b1;
         if (len % 2 == 0)
            twice_med = {1'b0, sort_mem[len/2-1]} + {1'b0, sort_mem[len/2]};
         else
            twice_med = {sort_mem[(len-1)/2], 1'b0};
         if ({1'b0, s} >= twice_med) begin
            v.notify = 1'b1;
            if (notice_tally != NOTICE_MAX) notice_tally++;
         end
         oldest = ring_mem[slot];
         k = 0;
         while (k < len && sort_mem[k] != oldest) k++;
         if (k >= len) k = len - 1;
         while (k + 1 < len) begin
            sort_mem[k] = sort_mem[k+1];
            k++;
         end
         sorted_add(len - 1, s);
         fill_cnt = len;
      end else begin
         sorted_add(fill_cnt, s);
         fill_cnt++;
      end
      ring_mem[slot] = s;
      ring_pos = (slot + 1) % len;
      v.notice_count = notice_tally;
      return v;
   endfunction

   function automatic sample_type draw_sample(sample_shape_type shape);
      sample_shape_type pick;
      pick = shape;
      if (shape == SHAPE_MIXED) pick = sample_shape_type'($urandom_range(0, 3));
      case (pick)
         SHAPE_LOW_SPIKE: begin
            if ($urandom_range(0, 99) < 85) return sample_type'($urandom_range(100, 400));
            return sample_type'($urandom_range(500, 65535));
         end
         SHAPE_DUPES: begin
            return sample_type'($urandom_range(0, 3) * $urandom_range(0, 2));
         end
         SHAPE_EDGES: begin
            case ($urandom_range(0, 5))
               0: return sample_type'(0);
               1: return sample_type'(1);
               2: return sample_type'(32767);
               3: return sample_type'(32768);
               4: return sample_type'(65534);
               default: return sample_type'(65535);
            endcase
         end
         default: return sample_type'($urandom);
      endcase
   endfunction

   // input beats
   always @(posedge clock) begin : send_proc
      int unsigned gap;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         gap = send_gap;
         if (req_valid && req_ready) begin
            queue_verdict(predict_spike(req_sample));
            gap = idle_draw(send_idle);
         end
         if (!req_valid || req_ready) begin
            if (gap != 0) begin
               req_valid <= 1'b0;
               send_gap  <= gap - 1;
            end else if (sample_q.size() != 0) begin
               req_valid  <= 1'b1;
               req_sample <= sample_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result beats
   always @(posedge clock) begin : recv_proc
      int unsigned       hold;
      spike_verdict_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap  <= 0;
         long_seen <= long_asks;
      end else begin
         hold = recv_gap;
         if (rsp_valid && rsp_ready) begin
            if (verdict_q.size() == 0) begin
               note_mismatch("unexpected result beat", 0, 1);
            end else begin
               want = verdict_q.pop_front();
               if (rsp_notify !== want.notify)
                  note_mismatch("notify", want.notify, rsp_notify);
               if (rsp_window_full !== want.window_full)
                  note_mismatch("window_full", want.window_full, rsp_window_full);
               if (rsp_notice_count !== want.notice_count)
                  note_mismatch("notice_count", want.notice_count, rsp_notice_count);
            end
            hold = idle_draw(recv_idle);
         end
         if (long_seen != long_asks) begin
            long_seen <= long_asks;
            hold = LONG_HOLD;
         end
         if (hold != 0) begin
            rsp_ready <= 1'b0;
            recv_gap  <= hold - 1;
         end else begin
            rsp_ready <= 1'b1;
            recv_gap  <= 0;
         end
      end
   end

   always @(posedge clock) begin : watchdog_proc
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat for %0d cycles", quiet_cycles);
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic wait_drained();
      while (sample_q.size() != 0 || verdict_q.size() != 0 || req_valid) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] data,
                             output logic [CSR_DATA_W-1:0] rd);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rd = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input int unsigned value);
      logic [CSR_DATA_W-1:0] data;
      logic [CSR_DATA_W-1:0] rd;
      wait_drained();
      repeat (8) @(posedge clock);
      data = (CSR_DATA_W'($urandom) & ~CSR_DATA_W'(9'h1FF)) | CSR_DATA_W'(value & 9'h1FF);
      csr_access(1'b1, addr, data, rd);
      if (addr == ADDR_WINDOW_LEN) begin
         len_reg  = data[LEN_W-1:0];
         fill_cnt = 0;
         ring_pos = 0;
      end
   endtask

   task automatic csr_check_len();
      logic [CSR_DATA_W-1:0] rd;
      csr_access(1'b0, ADDR_WINDOW_LEN, '0, rd);
      if (rd !== CSR_DATA_W'(len_reg)) note_mismatch("window_len readback", len_reg, rd);
   endtask

   task automatic run_phase(input int unsigned len, input int unsigned items,
                            input sample_shape_type shape, input logic s_idle,
                            input logic r_idle, input logic long_hold);
      csr_write(ADDR_WINDOW_LEN, len);
      csr_check_len();
      send_idle = s_idle;
      recv_idle = r_idle;
      repeat (items) queue_sample(draw_sample(shape));
      if (long_hold) long_asks++;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // window of one at reset
      csr_check_len();
      queue_sample(16'd0);
      queue_sample(16'd0);
      queue_sample(16'd65535);
      queue_sample(16'd65535);
      queue_sample(16'd32767);
      queue_sample(16'd65534);
      queue_sample(16'd1);
      queue_sample(16'd1);

      // write to an unused index leaves the window alone
      csr_write(ADDR_UNUSED, 9'h1FF);
      csr_check_len();
      queue_sample(16'd3);

      // zero length acts as one
      csr_write(ADDR_WINDOW_LEN, 0);
      csr_check_len();
      queue_sample(16'd7);
      queue_sample(16'd14);
      queue_sample(16'd13);

      csr_write(ADDR_WINDOW_LEN, 2);
      queue_sample(16'd10);
      queue_sample(16'd20);
      queue_sample(16'd30);
      queue_sample(16'd31);
      queue_sample(16'd0);

      csr_write(ADDR_WINDOW_LEN, 3);
      queue_sample(16'd5);
      queue_sample(16'd5);
      queue_sample(16'd5);
      queue_sample(16'd10);
      queue_sample(16'd9);
      queue_sample(16'd65535);

      run_phase(2,   120, SHAPE_LOW_SPIKE, 1'b1, 1'b1, 1'b0);
      run_phase(3,   120, SHAPE_DUPES,     1'b0, 1'b0, 1'b0);
      run_phase(5,   120, SHAPE_MIXED,     1'b0, 1'b1, 1'b1);
      run_phase(0,    60, SHAPE_MIXED,     1'b1, 1'b1, 1'b0);
      run_phase(8,   120, SHAPE_LOW_SPIKE, 1'b1, 1'b0, 1'b0);
      run_phase(16,  120, SHAPE_DUPES,     1'b1, 1'b1, 1'b0);
      run_phase(31,  120, SHAPE_UNIFORM,   1'b0, 1'b0, 1'b0);
      run_phase(256, 290, SHAPE_LOW_SPIKE, 1'b0, 1'b1, 1'b1);
      run_phase(511, 270, SHAPE_MIXED,     1'b0, 1'b0, 1'b0);
      run_phase(64,  130, SHAPE_DUPES,     1'b1, 1'b1, 1'b0);
      run_phase(4,   100, SHAPE_EDGES,     1'b1, 1'b1, 1'b0);

      wait_drained();
      repeat (12) @(posedge clock);
      if (fail_count == 0 && verdict_q.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
